>>> hdl/multi_level_task_queue_assert.svh
// Assertion macros used by the checker.
`ifndef MULTI_LEVEL_TASK_QUEUE_ASSERT_SVH
`define MULTI_LEVEL_TASK_QUEUE_ASSERT_SVH

// Property checked outside reset.
`define MLTQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("multi_level_task_queue check failed");

// Property checked at every edge, reset included.
`define MLTQ_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("multi_level_task_queue reset check failed");

`endif

>>> hdl/mltq_pkg.sv
package mltq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int LEVEL_COUNT_DEF = 3;

    localparam int REQ_W     = 2;
    localparam int TASK_W    = 8;
    localparam int PLEVEL_W  = 3;
    localparam int LIMIT_W   = 2;
    localparam int RUNLVL_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_POST      = 2'd0,
        REQ_DEQUEUE   = 2'd1,
        REQ_SET_LEVEL = 2'd2
    } t_req_type;

endpackage

>>> hdl/mltq_if.sv
interface mltq_req_if;
    logic                            valid;
    logic                            ready;
    logic [mltq_pkg::REQ_W-1:0]      req_type;
    logic [mltq_pkg::TASK_W-1:0]     task_id;
    logic [mltq_pkg::PLEVEL_W-1:0]   post_level;
    logic [mltq_pkg::LIMIT_W-1:0]    level_limit;

    modport source (output valid, req_type, task_id, post_level, level_limit, input ready);
    modport sink   (input valid, req_type, task_id, post_level, level_limit, output ready);
endinterface

interface mltq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic                            task_valid;
    logic [mltq_pkg::TASK_W-1:0]     task_out;
    logic [mltq_pkg::RUNLVL_W-1:0]   run_level;

    modport source (output valid, accepted, task_valid, task_out, run_level, input ready);
    modport sink   (input valid, accepted, task_valid, task_out, run_level, output ready);
endinterface

>>> hdl/multi_level_task_queue.sv
// Multilevel priority task queue.
// Requests arrive on i_req (valid/ready): post a task id to a level, dequeue
// the oldest task of the highest-priority nonempty level below a limit, or
// set the current run level. Every request gives exactly one response on
// o_rsp (valid/ready) with accepted, task_valid, task_out and run_level.
// A taken request passes the stage register r_s1, then the response register.
// One request per cycle while the receiver does not stall. Head, tail and
// fill count of each level sit in flops, so the level scan and the full
// check finish in the accept cycle; the task ids live in one RAM that takes
// one write (post) or one read (dequeue) per cycle, with registered read data.
// Reset (synchronous, active low) empties every level and sets the run level
// to the level count; the RAM needs no clearing since only filled slots are
// ever read.
// When the receiver stalls, the response register and one stage behind it
// hold their requests; i_req.ready drops once both are full.
module multi_level_task_queue #(
    parameter int QUEUE_DEPTH = mltq_pkg::QUEUE_DEPTH_DEF,
    parameter int LEVEL_COUNT = mltq_pkg::LEVEL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mltq_req_if.sink   i_req,
    mltq_rsp_if.source o_rsp
);

    localparam int IW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LIW   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int LW    = $clog2(LEVEL_COUNT + 1);
    localparam int DEPTH = LEVEL_COUNT * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = mltq_pkg::TASK_W;

    logic [IW-1:0] r_head [LEVEL_COUNT];
    logic [IW-1:0] n_head [LEVEL_COUNT];
    logic [IW-1:0] r_tail [LEVEL_COUNT];
    logic [IW-1:0] n_tail [LEVEL_COUNT];
    logic [CW-1:0] r_cnt  [LEVEL_COUNT];
    logic [CW-1:0] n_cnt  [LEVEL_COUNT];
    logic [LW-1:0] r_cur;
    logic [LW-1:0] n_cur;

    logic          r_s1_v;
    logic          r_s1_acc;
    logic          r_s1_tv;
    logic [LW-1:0] r_s1_lvl;
    logic          r_o_v;
    logic          r_o_acc;
    logic          r_o_tv;
    logic [TW-1:0] r_o_task;
    logic [LW-1:0] r_o_lvl;

    logic           req_fire;
    logic           s1_go;
    logic           pl_ok;
    logic [LIW-1:0] pl;
    logic           post_ok;
    logic [3:0]     lim4;
    logic           found;
    logic [LIW-1:0] sel;
    logic           res_acc;
    logic           res_tv;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [TW-1:0]  ram_rdata;

    assign i_req.ready = !r_s1_v || !r_o_v || o_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;
    assign s1_go       = r_s1_v && (!r_o_v || o_rsp.ready);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        res_acc   = 1'b0;
        res_tv    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        found     = 1'b0;
        sel       = '0;

        pl      = i_req.post_level[LIW-1:0];
        pl_ok   = {1'b0, i_req.post_level} < 4'(LEVEL_COUNT);
        post_ok = pl_ok && (i_req.task_id != '0) && (r_cnt[pl] != CW'(QUEUE_DEPTH));

        lim4 = ({2'b00, i_req.level_limit} > 4'(LEVEL_COUNT)) ?
               4'(LEVEL_COUNT) : {2'b00, i_req.level_limit};

        // first nonempty level below the limit
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            if (!found && (4'(l) < lim4) && (r_cnt[l] != '0)) begin
                found = 1'b1;
                sel   = LIW'(l);
            end
        end

        ram_waddr = AW'(int'(pl) * QUEUE_DEPTH + int'(r_tail[pl]));
        ram_raddr = AW'(int'(sel) * QUEUE_DEPTH + int'(r_head[sel]));

        if (req_fire) begin
            unique case (i_req.req_type)
                mltq_pkg::REQ_POST: begin
                    if (post_ok) begin
                        ram_we     = 1'b1;
                        res_acc    = 1'b1;
                        n_tail[pl] = (r_tail[pl] == IW'(QUEUE_DEPTH - 1)) ?
                                     '0 : r_tail[pl] + 1'b1;
                        n_cnt[pl]  = r_cnt[pl] + 1'b1;
                    end
                end
                mltq_pkg::REQ_DEQUEUE: begin
                    if (found) begin
                        ram_re      = 1'b1;
                        res_tv      = 1'b1;
                        n_head[sel] = (r_head[sel] == IW'(QUEUE_DEPTH - 1)) ?
                                      '0 : r_head[sel] + 1'b1;
                        n_cnt[sel]  = r_cnt[sel] - 1'b1;
                        n_cur       = LW'(sel);
                    end else begin
                        n_cur = LW'(lim4);
                    end
                end
                mltq_pkg::REQ_SET_LEVEL: begin
                    n_cur = LW'(lim4);
                end
                default: begin
                end
            endcase
        end
    end

    mltq_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.task_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_cur  <= LW'(LEVEL_COUNT);
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            if (req_fire) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_o_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload; RAM read data holds while the stage waits, no new read until it moves
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_acc <= res_acc;
            r_s1_tv  <= res_tv;
            r_s1_lvl <= n_cur;
        end
        if (s1_go) begin
            r_o_acc  <= r_s1_acc;
            r_o_tv   <= r_s1_tv;
            r_o_task <= r_s1_tv ? ram_rdata : '0;
            r_o_lvl  <= r_s1_lvl;
        end
    end

    assign o_rsp.valid      = r_o_v;
    assign o_rsp.accepted   = r_o_acc;
    assign o_rsp.task_valid = r_o_tv;
    assign o_rsp.task_out   = r_o_task;
    assign o_rsp.run_level  = mltq_pkg::RUNLVL_W'(r_o_lvl);

endmodule

>>> hdl/mltq_ram.sv
module mltq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/mltq_checker.sv
`include "multi_level_task_queue_assert.svh"

module mltq_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mltq_req_if.sink   i_req,
    mltq_rsp_if.source o_rsp
);

    logic rsp_hold;
    logic rsp_both;
    logic rsp_id_ok;
    logic req_open;

    assign rsp_hold  = o_rsp.valid && !o_rsp.ready;
    assign rsp_both  = o_rsp.accepted && o_rsp.task_valid;
    assign rsp_id_ok = o_rsp.task_valid == (o_rsp.task_out != '0);
    assign req_open  = !i_req.ready && !o_rsp.valid;

    // a post result and a dequeue result never mix
    `MLTQ_ASSERT(a_one_kind, i_clk, i_rst_n, o_rsp.valid |-> !rsp_both)
    // a found task is never the empty marker, and none shows without one
    `MLTQ_ASSERT(a_task_id, i_clk, i_rst_n, o_rsp.valid |-> rsp_id_ok)
    // the input side only blocks when the response side is full
    `MLTQ_ASSERT(a_no_block, i_clk, i_rst_n, !req_open)
    `MLTQ_ASSERT(a_hold, i_clk, i_rst_n, rsp_hold |=> o_rsp.valid)
    `MLTQ_ASSERT_ANY(a_rst_quiet, i_clk, !i_rst_n |=> !o_rsp.valid)

endmodule

bind multi_level_task_queue mltq_checker u_mltq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
